/* rtl/core/outer_vlan_tag_stripper_macros.svh */
// Assertion macros for the outer VLAN tag stripper checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef OUTER_VLAN_TAG_STRIPPER_MACROS_SVH
`define OUTER_VLAN_TAG_STRIPPER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, muted in reset.
`define OVTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ovts check failed");

// Next-cycle implication, sampled on the rising edge, muted in reset.
`define OVTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ovts check failed");

`endif

/* rtl/core/ovts_pkg.sv */
// Shared constants, codes and types of the outer VLAN tag stripper.
// No dependencies.
package ovts_pkg;

    localparam int OFFSET_W = 6;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX     = 6'd63;
    localparam logic [OFFSET_W-1:0] TYPE_HI_OFFSET = 6'd12;
    localparam logic [OFFSET_W-1:0] TYPE_LO_OFFSET = 6'd13;
    localparam logic [OFFSET_W-1:0] CTRL_HI_OFFSET = 6'd14;
    localparam logic [OFFSET_W-1:0] CTRL_LO_OFFSET = 6'd15;
    localparam logic [OFFSET_W-1:0] BASE_MIN_LEN   = 6'd14;
    localparam logic [OFFSET_W-1:0] TAG_LEN        = 6'd4;
    localparam logic [OFFSET_W-1:0] TAGGED_MIN_LEN = 6'd18;

    localparam int DEFAULT_TAG_DEPTH   = 5;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam int TYPE_W      = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [TYPE_W-1:0] TAG_TYPE_PRIMARY_RST   = 16'h8100;
    localparam logic [TYPE_W-1:0] TAG_TYPE_SECONDARY_RST = 16'h88A8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TAG_TYPE_PRIMARY   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAG_TYPE_SECONDARY = 1'b1;

    // result kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [TYPE_W-1:0]      data;
    } cfg_write_t;

    // All results caused by one accepted byte: up to two bytes, then a verdict.
    typedef struct packed {
        logic [1:0]        n_bytes;
        logic [7:0]        byte0;
        logic [7:0]        byte1;
        logic              verdict;
        logic              drop;
        logic              was_tagged;
        logic [TYPE_W-1:0] tag_control;
    } bundle_t;

endpackage

/* rtl/core/ovts_ifs.sv */
// Valid/ready channel interfaces of the outer VLAN tag stripper.
// No dependencies.
interface ovts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface ovts_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic        drop;
    logic        was_tagged;
    logic [15:0] tag_control;
    logic        run_last;

    modport source (output valid, kind, out_byte, drop, was_tagged, tag_control, run_last,
                    input ready);
    modport sink   (input valid, kind, out_byte, drop, was_tagged, tag_control, run_last,
                    output ready);
endinterface

/* rtl/core/ovts_queue.sv */
// Small FIFO of result bundles between the front and back parts.
// Depends on ovts_pkg.
module ovts_queue
    import ovts_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    push_ready,
    input  logic    pop,
    output bundle_t head,
    output logic    head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bundle_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/ovts_front.sv */
// Front part: accepts frame bytes, walks the tag chain, edits the header.
// Depends on ovts_pkg and ovts_ifs; emits a result bundle for each byte that causes results.
module ovts_front
    import ovts_pkg::*;
#(
    parameter int MAX_TAG_DEPTH = DEFAULT_TAG_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    ovts_byte_if.sink  rx,
    output logic       push,
    output bundle_t    push_data,
    input  logic       push_ready
);

    localparam int CHAIN_END_I = int'(TYPE_HI_OFFSET) + int'(TAG_LEN) * MAX_TAG_DEPTH;
    localparam logic [OFFSET_W-1:0] CHAIN_END = OFFSET_W'(CHAIN_END_I);
    localparam logic [1:0] PHASE_TYPE_HI = 2'd0;
    localparam logic [1:0] PHASE_TYPE_LO = 2'd1;

    logic [TYPE_W-1:0]   type_primary_reg;
    logic [TYPE_W-1:0]   type_secondary_reg;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [7:0]          held_reg, held_next;
    logic                chain_open_reg, chain_open_next;
    logic [OFFSET_W-1:0] needed_reg, needed_next;
    logic                outer_reg, outer_next;
    logic [TYPE_W-1:0]   ctrl_reg, ctrl_next;

    logic                accept;
    logic                in_chain;
    logic [1:0]          phase;
    logic                is_tag;
    logic                drop_now;

    assign rx.ready = push_ready;
    assign accept   = rx.valid && push_ready;
    assign in_chain = (offset_reg >= TYPE_HI_OFFSET) && (offset_reg < CHAIN_END);
    assign phase    = 2'(offset_reg - TYPE_HI_OFFSET);
    assign is_tag   = ({held_reg, rx.frame_byte} == type_primary_reg)
                   || ({held_reg, rx.frame_byte} == type_secondary_reg);

    always_comb
    begin
        held_next       = held_reg;
        chain_open_next = chain_open_reg;
        needed_next     = needed_reg;
        outer_next      = outer_reg;
        ctrl_next       = ctrl_reg;
        offset_next     = (offset_reg == OFFSET_MAX) ? offset_reg : offset_reg + 1'b1;

        push_data         = '0;
        push_data.byte0   = rx.frame_byte;
        push_data.n_bytes = 2'd1;

        // tag chain walk
        if (in_chain && (phase == PHASE_TYPE_HI))
        begin
            held_next = rx.frame_byte;
        end
        else if (in_chain && (phase == PHASE_TYPE_LO) && chain_open_reg)
        begin
            if (is_tag)
            begin
                needed_next = needed_reg + TAG_LEN;
            end
            else
            begin
                chain_open_next = 1'b0;
            end
        end

        // header editing
        case (offset_reg)
            TYPE_HI_OFFSET:
            begin
                // hold the type byte until the next one decides, unless the frame ends here
                push_data.n_bytes = rx.frame_end ? 2'd1 : 2'd0;
            end
            TYPE_LO_OFFSET:
            begin
                if (is_tag)
                begin
                    outer_next        = 1'b1;
                    push_data.n_bytes = 2'd0;
                end
                else
                begin
                    push_data.n_bytes = 2'd2;
                    push_data.byte0   = held_reg;
                    push_data.byte1   = rx.frame_byte;
                end
            end
            default:
            begin
                if ((offset_reg inside {CTRL_HI_OFFSET, CTRL_LO_OFFSET}) && outer_reg)
                begin
                    ctrl_next         = {ctrl_reg[7:0], rx.frame_byte};
                    push_data.n_bytes = 2'd0;
                end
            end
        endcase

        drop_now = (offset_next < needed_next) || (outer_next && (offset_next < TAGGED_MIN_LEN));
        push_data.verdict     = rx.frame_end;
        push_data.drop        = drop_now;
        push_data.was_tagged  = outer_next;
        push_data.tag_control = outer_next ? ctrl_next : '0;

        push = accept && ((push_data.n_bytes != 2'd0) || rx.frame_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_primary_reg   <= TAG_TYPE_PRIMARY_RST;
            type_secondary_reg <= TAG_TYPE_SECONDARY_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_TAG_TYPE_PRIMARY:   type_primary_reg   <= cfg.data;
                CFG_TAG_TYPE_SECONDARY: type_secondary_reg <= cfg.data;
                default:                type_primary_reg   <= type_primary_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            held_reg       <= '0;
            chain_open_reg <= 1'b1;
            needed_reg     <= BASE_MIN_LEN;
            outer_reg      <= 1'b0;
            ctrl_reg       <= '0;
        end
        else if (accept)
        begin
            if (rx.frame_end)
            begin
                // verdict issued: start the next frame afresh
                offset_reg     <= '0;
                held_reg       <= '0;
                chain_open_reg <= 1'b1;
                needed_reg     <= BASE_MIN_LEN;
                outer_reg      <= 1'b0;
                ctrl_reg       <= '0;
            end
            else
            begin
                offset_reg     <= offset_next;
                held_reg       <= held_next;
                chain_open_reg <= chain_open_next;
                needed_reg     <= needed_next;
                outer_reg      <= outer_next;
                ctrl_reg       <= ctrl_next;
            end
        end
    end

endmodule

/* rtl/core/ovts_back.sv */
// Back part: unpacks result bundles into single results on the output channel.
// Depends on ovts_pkg and ovts_ifs.
module ovts_back
    import ovts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bundle_t       head,
    input  logic          head_valid,
    output logic          pop,
    ovts_result_if.source tx
);

    logic [1:0]        sel_reg;
    logic              valid_reg;
    logic              kind_reg;
    logic [7:0]        byte_reg;
    logic              drop_reg;
    logic              tagged_reg;
    logic [TYPE_W-1:0] ctrl_reg;
    logic              last_reg;

    logic [1:0]        total;
    logic              is_last;
    logic              is_byte;
    logic              load;

    assign total   = head.n_bytes + {1'b0, head.verdict};
    assign is_last = ((sel_reg + 2'd1) == total);
    assign is_byte = (sel_reg < head.n_bytes);
    assign load    = head_valid && (!valid_reg || tx.ready);
    assign pop     = load && is_last;

    assign tx.valid       = valid_reg;
    assign tx.kind        = kind_reg;
    assign tx.out_byte    = byte_reg;
    assign tx.drop        = drop_reg;
    assign tx.was_tagged  = tagged_reg;
    assign tx.tag_control = ctrl_reg;
    assign tx.run_last    = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= is_last;
            if (is_byte)
            begin
                kind_reg   <= KIND_BYTE;
                byte_reg   <= (sel_reg == 2'd0) ? head.byte0 : head.byte1;
                drop_reg   <= 1'b0;
                tagged_reg <= 1'b0;
                ctrl_reg   <= '0;
            end
            else
            begin
                kind_reg   <= KIND_VERDICT;
                byte_reg   <= '0;
                drop_reg   <= head.drop;
                tagged_reg <= head.was_tagged;
                ctrl_reg   <= head.tag_control;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            sel_reg   <= is_last ? 2'd0 : sel_reg + 2'd1;
        end
        else if (tx.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

/* rtl/core/outer_vlan_tag_stripper.sv */
// Outer VLAN tag stripper, top level.
// Depends on ovts_pkg, ovts_ifs, ovts_front, ovts_queue and ovts_back.
//
// Usage:
//   rx carries one frame byte per request, frame_end marking the last byte.
//   tx carries results: edited frame bytes (kind 0) and one verdict per
//   frame (kind 1) with drop, was_tagged and the removed tag control word;
//   run_last marks the last result caused by a given byte.
//   The cfg port writes the two tag protocol identifiers (index 0 and 1).
//   Write them only while no frame is in flight.
// Timing:
//   Results pass the queue and a registered output stage. rx takes one byte
//   per cycle while the queue has room; tx shows one result per cycle while
//   ready is high. Bytes that cause two or three results (untagged type
//   field, frame end) are absorbed by the bundle queue between the front and
//   back parts, whose depth sets how long rx keeps going while tx drains.
// Reset:
//   rst_n clears the frame state, empties the queue and restores the
//   identifiers to 0x8100 and 0x88A8.
// Stall:
//   When tx is held off, hold the current result, fill the queue, then drop
//   rx ready until space returns. Nothing is lost or repeated.
module outer_vlan_tag_stripper
    import ovts_pkg::*;
#(
    parameter int MAX_TAG_DEPTH = DEFAULT_TAG_DEPTH,
    parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TYPE_W-1:0]      cfg_data,
    ovts_byte_if.sink              rx,
    ovts_result_if.source          tx
);

    cfg_write_t cfg;
    bundle_t    push_data;
    bundle_t    head;
    logic       push;
    logic       push_ready;
    logic       pop;
    logic       head_valid;

    // gather the write port into one group for the front part
    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // front: classify bytes and bundle their results
    ovts_front #(
        .MAX_TAG_DEPTH (MAX_TAG_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .rx         (rx),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // queue: decouple the byte side from the result side
    ovts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // back: issue the bundled results one at a time
    ovts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .tx         (tx)
    );

endmodule

/* rtl/core/ovts_checker.sv */
// Port-level checks on the result channel of the outer VLAN tag stripper.
// Depends on ovts_pkg and outer_vlan_tag_stripper_macros.svh; bound to the top.
`include "outer_vlan_tag_stripper_macros.svh"

module ovts_checker
    import ovts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        tx_valid,
    input logic        tx_ready,
    input logic        tx_kind,
    input logic [7:0]  tx_out_byte,
    input logic        tx_drop,
    input logic        tx_was_tagged,
    input logic [15:0] tx_tag_control,
    input logic        tx_run_last
);

    `OVTS_ASSERT_NEXT(a_stall_hold, tx_valid && !tx_ready, tx_valid && $stable(tx_kind) && $stable(tx_out_byte) && $stable(tx_tag_control) && $stable(tx_run_last))
    `OVTS_ASSERT_NOW(a_verdict_last, tx_valid && (tx_kind == KIND_VERDICT), tx_run_last)
    `OVTS_ASSERT_NOW(a_byte_clean, tx_valid && (tx_kind == KIND_BYTE), !tx_drop && !tx_was_tagged && (tx_tag_control == 16'd0))
    `OVTS_ASSERT_NOW(a_untagged_ctrl, tx_valid && (tx_kind == KIND_VERDICT) && !tx_was_tagged, tx_tag_control == 16'd0)

endmodule

bind outer_vlan_tag_stripper ovts_checker u_ovts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tx_valid       (tx.valid),
    .tx_ready       (tx.ready),
    .tx_kind        (tx.kind),
    .tx_out_byte    (tx.out_byte),
    .tx_drop        (tx.drop),
    .tx_was_tagged  (tx.was_tagged),
    .tx_tag_control (tx.tag_control),
    .tx_run_last    (tx.run_last)
);

/* tb/outer_vlan_tag_stripper_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the outer VLAN tag stripper: predicts results from accepted bytes and
// compares them with the result channel. Depends on ovts_pkg and the ovts_ifs interfaces.
module outer_vlan_tag_stripper_checker
    import ovts_pkg::*;
#(
    parameter int TAG_DEPTH = DEFAULT_TAG_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TYPE_W-1:0]      cfg_data,
    ovts_byte_if                   rx,
    ovts_result_if                 tx,
    output int                     error_count,
    output int                     results_owed
);

    typedef struct packed {
        logic              kind;
        logic [7:0]        out_byte;
        logic              drop;
        logic              was_tagged;
        logic [TYPE_W-1:0] tag_control;
        logic              run_last;
    } vlan_result_t;

    // configured tag protocol identifiers
    logic [TYPE_W-1:0]   tpid_primary;
    logic [TYPE_W-1:0]   tpid_secondary;

    // per-frame state of the stripper
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          type_hi;
    logic                chain_live;
    logic [OFFSET_W-1:0] min_len;
    logic                tag_stripped;
    logic [TYPE_W-1:0]   tci;

    vlan_result_t        owed_results[$];
    vlan_result_t        got;
    vlan_result_t        want;

    function automatic bit is_tpid(input logic [TYPE_W-1:0] type_id);
        return type_id == tpid_primary || type_id == tpid_secondary;
    endfunction

    function automatic vlan_result_t byte_result(input logic [7:0] value);
        vlan_result_t res;
        res          = '0;
        res.kind     = KIND_BYTE;
        res.out_byte = value;
        return res;
    endfunction

    function automatic void clear_frame();
        offset       = '0;
        type_hi      = '0;
        chain_live   = 1'b1;
        min_len      = BASE_MIN_LEN;
        tag_stripped = 1'b0;
        tci          = '0;
    endfunction

    // Work out every result one accepted byte causes and queue them in order.
    function automatic void predict_byte(input logic [7:0] value, input logic is_last);
        vlan_result_t        res [3];
        int                  n;
        int                  o;
        int                  chain_end;
        logic [OFFSET_W-1:0] len;
        n         = 0;
        o         = int'(offset);
        chain_end = int'(TYPE_HI_OFFSET) + int'(TAG_LEN) * TAG_DEPTH;

        // walk the tag chain: one type field every four bytes from offset 12
        if (o >= int'(TYPE_HI_OFFSET) && o < chain_end)
        begin
            if ((o - int'(TYPE_HI_OFFSET)) % 4 == 0)
                type_hi = value;
            else if ((o - int'(TYPE_HI_OFFSET)) % 4 == 1 && chain_live)
            begin
                if (is_tpid({type_hi, value}))
                    min_len = min_len + TAG_LEN;
                else
                    chain_live = 1'b0;
            end
        end

        if (offset == TYPE_HI_OFFSET)
        begin
            // hold the high type byte unless the frame stops here
            if (is_last)
            begin
                res[n] = byte_result(value);
                n++;
            end
        end
        else if (offset == TYPE_LO_OFFSET)
        begin
            if (is_tpid({type_hi, value}))
                tag_stripped = 1'b1;
            else
            begin
                res[n] = byte_result(type_hi);
                n++;
                res[n] = byte_result(value);
                n++;
            end
        end
        else if ((offset == CTRL_HI_OFFSET || offset == CTRL_LO_OFFSET) && tag_stripped)
            tci = {tci[7:0], value};
        else
        begin
            res[n] = byte_result(value);
            n++;
        end

        if (offset != OFFSET_MAX)
            offset = offset + 1'b1;

        if (is_last)
        begin
            len                = offset;
            res[n]             = '0;
            res[n].kind        = KIND_VERDICT;
            res[n].drop        = (len < min_len) || (tag_stripped && len < TAGGED_MIN_LEN);
            res[n].was_tagged  = tag_stripped;
            res[n].tag_control = tag_stripped ? tci : '0;
            n++;
            clear_frame();
        end

        if (n > 0)
            res[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            owed_results.push_back(res[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpid_primary   = TAG_TYPE_PRIMARY_RST;
            tpid_secondary = TAG_TYPE_SECONDARY_RST;
            clear_frame();
            owed_results.delete();
            error_count    = 0;
            results_owed   = 0;
        end
        else
        begin
            if (tx.valid && tx.ready)
            begin
                got = '{kind: tx.kind, out_byte: tx.out_byte, drop: tx.drop,
                        was_tagged: tx.was_tagged, tag_control: tx.tag_control,
                        run_last: tx.run_last};
                if (owed_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 20)
                        $display("%0t: unexpected result kind=%0d byte=%02h drop=%0d tagged=%0d tci=%04h last=%0d",
                                 $time, got.kind, got.out_byte, got.drop, got.was_tagged,
                                 got.tag_control, got.run_last);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= 20)
                            $display("%0t: mismatch expected kind=%0d byte=%02h drop=%0d tagged=%0d tci=%04h last=%0d, actual kind=%0d byte=%02h drop=%0d tagged=%0d tci=%04h last=%0d",
                                     $time, want.kind, want.out_byte, want.drop,
                                     want.was_tagged, want.tag_control, want.run_last,
                                     got.kind, got.out_byte, got.drop, got.was_tagged,
                                     got.tag_control, got.run_last);
                    end
                end
            end

            if (rx.valid && rx.ready)
                predict_byte(rx.frame_byte, rx.frame_end);

            if (cfg_we)
            begin
                if (cfg_index == CFG_TAG_TYPE_PRIMARY)
                    tpid_primary = cfg_data;
                else if (cfg_index == CFG_TAG_TYPE_SECONDARY)
                    tpid_secondary = cfg_data;
            end

            results_owed = owed_results.size();
        end
    end

endmodule

/* tb/outer_vlan_tag_stripper_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the outer VLAN tag stripper: clock, reset, frame stimulus, result
// back-pressure and the final verdict. Depends on ovts_pkg, ovts_ifs and the checker.
module outer_vlan_tag_stripper_tb;
    import ovts_pkg::*;

    localparam int TAG_DEPTH        = DEFAULT_TAG_DEPTH;
    localparam int BYTES_PER_PHASE  = 52;      // random bytes per identifier setting
    localparam int HOLD_OFF_CYCLES  = 200;     // long receiver hold-off, fills the queue
    localparam int DRAIN_CYCLES     = 12;      // output register plus queue, with margin
    localparam int CYCLE_LIMIT      = 400000;  // several times the slowest legal run

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TYPE_W-1:0]      cfg_data;

    ovts_byte_if   rx_if ();
    ovts_result_if tx_if ();

    int                error_count;
    int                results_owed;
    int                cycle_count;

    // identifiers currently programmed, used to build well-formed tag chains
    logic [TYPE_W-1:0] tpid_p;
    logic [TYPE_W-1:0] tpid_s;

    logic [7:0]        frame_q[$];
    bit                rx_calm;     // no sender gaps for the current frame
    bit                long_hold;   // ask the receiver for one long hold-off

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    outer_vlan_tag_stripper #(
        .MAX_TAG_DEPTH (TAG_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_if),
        .tx        (tx_if)
    );

    outer_vlan_tag_stripper_checker #(
        .TAG_DEPTH (TAG_DEPTH)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx           (rx_if),
        .tx           (tx_if),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    // Result side. Alternate calm stretches (always ready) with busy ones (short stalls
    // and the odd long one). On request, hold ready low for a long fixed stretch while
    // the sender keeps offering bytes, so the internal queue fills and rx backs off.
    initial
    begin
        int stall_left;
        int phase_left;
        int r;
        bit busy;
        tx_if.ready <= 1'b0;
        stall_left = 0;
        phase_left = 0;
        busy       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                tx_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                tx_if.ready <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    busy       = !busy;
                    phase_left = $urandom_range(150, 500);
                end
                phase_left--;
                if (!busy)
                    tx_if.ready <= 1'b1;
                else if (stall_left > 0)
                begin
                    tx_if.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    tx_if.ready <= 1'b1;
                    r = $urandom_range(0, 99);
                    if (r < 25)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 28)
                        stall_left = $urandom_range(20, 50);
                end
            end
        end
    end

    // Watchdog: give up on a hung run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL outer_vlan_tag_stripper");
        $finish;
    end

    // Offer one byte, with a random idle gap ahead of it unless the frame is calm, and
    // return at the edge where the request is taken.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        int r;
        gap = 0;
        if (!rx_calm)
        begin
            r = $urandom_range(0, 99);
            if (r >= 94)
                gap = $urandom_range(10, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid      <= 1'b1;
        rx_if.frame_byte <= value;
        rx_if.frame_end  <= is_last;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
    endtask

    task automatic push_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Build a random frame: mostly 18..40 bytes with a chain of programmed tag types,
    // some runts cut inside the header or the tag, a few running past the offset
    // counter's saturation. Chains may exceed the walk depth; sometimes the type after
    // the chain is a near miss (one bit off an identifier).
    task automatic fill_random_frame();
        int                len;
        int                levels;
        int                at;
        int                r;
        logic [TYPE_W-1:0] tag;
        r = $urandom_range(0, 99);
        if (r < 12)
            len = $urandom_range(1, 17);
        else if (r < 92)
            len = $urandom_range(18, 40);
        else
            len = $urandom_range(60, 80);
        frame_q.delete();
        for (int i = 0; i < len; i++)
            frame_q.push_back(8'($urandom_range(0, 255)));

        levels = ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(1, TAG_DEPTH + 1);
        for (int k = 0; k < levels; k++)
        begin
            at  = 12 + 4 * k;
            tag = $urandom_range(0, 1) ? tpid_p : tpid_s;
            if (at < len)
                frame_q[at] = tag[15:8];
            if (at + 1 < len)
                frame_q[at + 1] = tag[7:0];
        end
        if ($urandom_range(0, 3) == 0)
        begin
            at  = 12 + 4 * levels;
            tag = $urandom_range(0, 1) ? tpid_p : tpid_s;
            tag = tag ^ (16'h1 << $urandom_range(0, 15));
            if (at < len)
                frame_q[at] = tag[15:8];
            if (at + 1 < len)
                frame_q[at + 1] = tag[7:0];
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle.
    task automatic wait_for_drain();
        rx_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Program both identifiers on consecutive edges; only called while idle.
    task automatic set_tpids(input logic [TYPE_W-1:0] primary,
                             input logic [TYPE_W-1:0] secondary);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAG_TYPE_PRIMARY;
        cfg_data  <= primary;
        @(posedge clk);
        cfg_index <= CFG_TAG_TYPE_SECONDARY;
        cfg_data  <= secondary;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tpid_p = primary;
        tpid_s = secondary;
    endtask

    initial
    begin
        int                sent;
        logic [TYPE_W-1:0] r16;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_TAG_TYPE_PRIMARY;
        cfg_data         <= '0;
        rx_if.valid      <= 1'b0;
        rx_if.frame_byte <= '0;
        rx_if.frame_end  <= 1'b0;
        tpid_p    = TAG_TYPE_PRIMARY_RST;
        tpid_s    = TAG_TYPE_SECONDARY_RST;
        rx_calm   = 1'b0;
        long_hold = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset identifiers.
        // One-byte runt of all ones: byte, then a drop verdict.
        frame_q = '{8'hFF};
        push_frame();
        // Frame ending on the held high type byte: release it, then the verdict.
        frame_q.delete();
        repeat (12) frame_q.push_back(8'h00);
        frame_q.push_back(8'h81);
        push_frame();
        // Tagged frame ending inside the tag: partial control word, dropped.
        frame_q.delete();
        for (int i = 0; i < 12; i++)
            frame_q.push_back(i[0] ? 8'hFF : 8'h00);
        frame_q.push_back(8'h81);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hAB);
        push_frame();

        // Random frames under a series of identifier settings, extremes included.
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
            begin
                wait_for_drain();
                case (phase)
                    1: set_tpids(16'h0000, 16'hFFFF);
                    2:
                    begin
                        r16 = 16'($urandom_range(0, 65535));
                        set_tpids(r16, r16);
                    end
                    3: set_tpids(16'hFFFF, 16'h0000);
                    4: set_tpids(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                    default: set_tpids(TAG_TYPE_PRIMARY_RST, TAG_TYPE_SECONDARY_RST);
                endcase
            end
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
                if ((phase == 1 || phase == 4) && sent == 0)
                begin
                    // keep offering back to back through the hold-off
                    long_hold = 1'b1;
                    rx_calm   = 1'b1;
                end
                fill_random_frame();
                push_frame();
                sent += frame_q.size();
            end
        end

        wait_for_drain();
        @(negedge clk);
        if (error_count == 0 && results_owed == 0)
            $display("PASS outer_vlan_tag_stripper");
        else
            $display("FAIL outer_vlan_tag_stripper");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ovts_pkg.sv
rtl/core/ovts_ifs.sv
rtl/core/ovts_queue.sv
rtl/core/ovts_front.sv
rtl/core/ovts_back.sv
rtl/core/outer_vlan_tag_stripper.sv
rtl/core/ovts_checker.sv
tb/outer_vlan_tag_stripper_checker.sv
tb/outer_vlan_tag_stripper_tb.sv
